[hw/rtl/rtt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_pkg
// shared types and constants for the range top-two extremes tree
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int VAL_W = 32;
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_RDL,
    ST_W_RDR,
    ST_W_UPD,
    ST_Q_LOOP,
    ST_Q_BW,
    ST_Q_ECHK,
    ST_Q_EW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic clr_step;
    logic leaf_wr;
    logic rd_left;
    logic rd_right;
    logic upd;
    logic q_rd_b;
    logic q_merge_b;
    logic q_rd_e;
    logic q_merge_e;
    logic q_shift;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pos_ok;
    logic k_one;
    logic b_lt_e;
    logic b_odd;
    logic e_odd;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/range_top_two_extremes_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_top_two_extremes_tree
// segment tree holding the two largest and two smallest values per node
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall, transfer when valid and not stall.
//   action 0 writes in_value at in_position and rebuilds the path to the root;
//   action 1 queries [in_position, in_range_end) and gives one result.
// result channel: out_valid / out_stall with an output register, so the next
//   item is taken while a result still waits.
// one item at a time: a write stores the leaf, then per level reads the left
//   child, reads the right child, and merges and writes back, on the single
//   read port of the node memory; a query walks both range ends up the tree,
//   merging the border nodes, and the input stalls until the item is done.
// reset: a clearing pass writes every node of the 2 * DEPTH node memory as
//   empty, with in_stall high.
// when the receiver stalls, a finished query holds until the output register
//   frees, and the input stalls meanwhile.
// ----------------------------------------------------------------------------
module range_top_two_extremes_tree #(
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [$clog2(DEPTH)-1:0]         in_position,
  input  logic [$clog2(DEPTH):0]           in_range_end,
  input  logic signed [rtt_pkg::VAL_W-1:0] in_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [$clog2(DEPTH):0]    out_largest_pos,
  output logic signed [$clog2(DEPTH):0]    out_second_largest_pos,
  output logic signed [$clog2(DEPTH):0]    out_smallest_pos,
  output logic signed [$clog2(DEPTH):0]    out_second_smallest_pos,
  output logic signed [rtt_pkg::VAL_W-1:0] out_largest_val,
  output logic signed [rtt_pkg::VAL_W-1:0] out_second_largest_val,
  output logic signed [rtt_pkg::VAL_W-1:0] out_smallest_val,
  output logic signed [rtt_pkg::VAL_W-1:0] out_second_smallest_val
);
  import rtt_pkg::*;

  cmd_t    cmd;
  status_t sts;

  rtt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rtt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_position             (in_position),
    .in_range_end            (in_range_end),
    .in_value                (in_value),
    .out_stall               (out_stall),
    .out_valid               (out_valid),
    .out_largest_pos         (out_largest_pos),
    .out_second_largest_pos  (out_second_largest_pos),
    .out_smallest_pos        (out_smallest_pos),
    .out_second_smallest_pos (out_second_smallest_pos),
    .out_largest_val         (out_largest_val),
    .out_second_largest_val  (out_second_largest_val),
    .out_smallest_val        (out_smallest_val),
    .out_second_smallest_val (out_second_smallest_val)
  );

endmodule

[hw/rtl/rtt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module rtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rtt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_ctrl
// sequencer for clear pass, write path update and range query walk
// ----------------------------------------------------------------------------
module rtt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_stall,
  input  rtt_pkg::status_t sts,
  output rtt_pkg::cmd_t    cmd
);
  import rtt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_action == ACT_QUERY) ? ST_Q_LOOP : ST_W_LEAF;
      end
      ST_W_LEAF: state_nxt = sts.pos_ok ? ST_W_RDL : ST_IDLE;
      ST_W_RDL:  state_nxt = ST_W_RDR;
      ST_W_RDR:  state_nxt = ST_W_UPD;
      ST_W_UPD:  state_nxt = sts.k_one ? ST_IDLE : ST_W_RDL;
      ST_Q_LOOP: begin
        if (!sts.b_lt_e) state_nxt = ST_OUT;
        else if (sts.b_odd) state_nxt = ST_Q_BW;
        else state_nxt = ST_Q_ECHK;
      end
      ST_Q_BW:   state_nxt = ST_Q_ECHK;
      ST_Q_ECHK: state_nxt = sts.e_odd ? ST_Q_EW : ST_Q_LOOP;
      ST_Q_EW:   state_nxt = ST_Q_LOOP;
      ST_OUT:    if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_CLEAR:  cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_W_LEAF: cmd.leaf_wr = sts.pos_ok;
      ST_W_RDL:  cmd.rd_left = 1'b1;
      ST_W_RDR:  cmd.rd_right = 1'b1;
      ST_W_UPD:  cmd.upd = 1'b1;
      ST_Q_LOOP: cmd.q_rd_b = sts.b_lt_e && sts.b_odd;
      ST_Q_BW:   cmd.q_merge_b = 1'b1;
      ST_Q_ECHK: begin
        cmd.q_rd_e = sts.e_odd;
        cmd.q_shift = !sts.e_odd;
      end
      ST_Q_EW:   cmd.q_merge_e = 1'b1;
      ST_OUT:    cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

endmodule

[hw/rtl/rtt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtt_dp
// node memory, index counters, node merge unit and result register
// ----------------------------------------------------------------------------
module rtt_dp #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rtt_pkg::cmd_t                       cmd,
  output rtt_pkg::status_t                    sts,
  input  logic [$clog2(DEPTH)-1:0]            in_position,
  input  logic [$clog2(DEPTH):0]              in_range_end,
  input  logic signed [rtt_pkg::VAL_W-1:0]    in_value,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [$clog2(DEPTH):0]       out_largest_pos,
  output logic signed [$clog2(DEPTH):0]       out_second_largest_pos,
  output logic signed [$clog2(DEPTH):0]       out_smallest_pos,
  output logic signed [$clog2(DEPTH):0]       out_second_smallest_pos,
  output logic signed [rtt_pkg::VAL_W-1:0]    out_largest_val,
  output logic signed [rtt_pkg::VAL_W-1:0]    out_second_largest_val,
  output logic signed [rtt_pkg::VAL_W-1:0]    out_smallest_val,
  output logic signed [rtt_pkg::VAL_W-1:0]    out_second_smallest_val
);
  import rtt_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int AW = PW + 1;
  localparam int IW = PW + 2;
  localparam int SW = 1 + PW + VAL_W;
  localparam int NW = 4 * SW;
  localparam int ND = 2 * DEPTH;
  localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);
  localparam logic [AW-1:0] CLR_LAST = AW'(ND - 1);

  // slot: valid, position, value
  function automatic logic ranks(input logic [SW-1:0] x, input logic [SW-1:0] y,
                                 input logic mx);
    logic signed [VAL_W-1:0] vx;
    logic signed [VAL_W-1:0] vy;
    logic r;
    vx = x[VAL_W-1:0];
    vy = y[VAL_W-1:0];
    if (!x[SW-1]) r = 1'b0;
    else if (!y[SW-1]) r = 1'b1;
    else if (vx != vy) r = mx ? (vx > vy) : (vx < vy);
    else r = x[SW-2:VAL_W] < y[SW-2:VAL_W];
    return r;
  endfunction

  function automatic logic [2*SW-1:0] merge(input logic [SW-1:0] a0, input logic [SW-1:0] a1,
                                            input logic [SW-1:0] b0, input logic [SW-1:0] b1,
                                            input logic mx);
    logic [2*SW-1:0] r;
    if (ranks(a0, b0, mx)) r = {a0, ranks(a1, b0, mx) ? a1 : b0};
    else r = {b0, ranks(a0, b1, mx) ? a0 : b1};
    return r;
  endfunction

  function automatic logic [NW-1:0] combine(input logic [NW-1:0] a, input logic [NW-1:0] b);
    logic [2*SW-1:0] hi;
    logic [2*SW-1:0] lo;
    hi = merge(a[4*SW-1 -: SW], a[3*SW-1 -: SW], b[4*SW-1 -: SW], b[3*SW-1 -: SW], 1'b1);
    lo = merge(a[2*SW-1 -: SW], a[SW-1 -: SW], b[2*SW-1 -: SW], b[SW-1 -: SW], 1'b0);
    return {hi, lo};
  endfunction

  function automatic logic [PW:0] slot_pos(input logic [SW-1:0] s);
    return s[SW-1] ? {1'b0, s[SW-2:VAL_W]} : '1;
  endfunction

  function automatic logic [VAL_W-1:0] slot_val(input logic [SW-1:0] s,
                                                input logic [VAL_W-1:0] sentinel);
    return s[SW-1] ? s[VAL_W-1:0] : sentinel;
  endfunction

  logic [IW-1:0]    b_r;
  logic [IW-1:0]    e_r;
  logic [IW-1:0]    e_m1;
  logic [IW-1:0]    end_c;
  logic [AW-1:0]    clr_r;
  logic [PW-1:0]    pos_r;
  logic [VAL_W-1:0] val_r;
  logic [NW-1:0]    left_r;
  logic [NW-1:0]    acc_r;
  logic [NW-1:0]    res_r;
  logic             out_valid_r;
  logic [NW-1:0]    rdata;
  logic [NW-1:0]    wdata;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic             we;
  logic [SW-1:0]    leaf;

  assign e_m1 = e_r - IW'(1);
  assign end_c = ({1'b0, in_range_end} > DEPTH_I) ? DEPTH_I : {1'b0, in_range_end};
  assign leaf = {1'b1, pos_r, val_r};

  always_comb begin
    we = cmd.clr_step | cmd.leaf_wr | cmd.upd;
    waddr = cmd.clr_step ? clr_r : b_r[AW-1:0];
    if (cmd.clr_step) wdata = '0;
    else if (cmd.leaf_wr) wdata = {leaf, {SW{1'b0}}, leaf, {SW{1'b0}}};
    else wdata = combine(left_r, rdata);
    if (cmd.rd_left) raddr = {b_r[PW-1:0], 1'b0};
    else if (cmd.rd_right) raddr = {b_r[PW-1:0], 1'b1};
    else if (cmd.q_rd_e) raddr = e_m1[AW-1:0];
    else raddr = b_r[AW-1:0];
  end

  rtt_ram #(
    .WIDTH (NW),
    .DEPTH (ND)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      pos_r <= in_position;
      val_r <= in_value;
      b_r <= {2'b00, in_position} + DEPTH_I;
      e_r <= end_c + DEPTH_I;
      acc_r <= '0;
    end
    if (cmd.leaf_wr || cmd.upd || cmd.q_shift) b_r <= b_r >> 1;
    if (cmd.q_shift) e_r <= e_r >> 1;
    if (cmd.rd_right) left_r <= rdata;
    if (cmd.q_merge_b) begin
      acc_r <= combine(acc_r, rdata);
      b_r <= b_r + IW'(1);
    end
    if (cmd.q_merge_e) begin
      acc_r <= combine(rdata, acc_r);
      e_r <= e_m1 >> 1;
      b_r <= b_r >> 1;
    end
    if (cmd.out_load) res_r <= acc_r;
  end

  assign sts.clr_last = (clr_r == CLR_LAST);
  assign sts.pos_ok   = ({2'b00, pos_r} < DEPTH_I);
  assign sts.k_one    = (b_r == IW'(1));
  assign sts.b_lt_e   = (b_r < e_r);
  assign sts.b_odd    = b_r[0];
  assign sts.e_odd    = e_r[0];
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_largest_pos         = slot_pos(res_r[4*SW-1 -: SW]);
  assign out_second_largest_pos  = slot_pos(res_r[3*SW-1 -: SW]);
  assign out_smallest_pos        = slot_pos(res_r[2*SW-1 -: SW]);
  assign out_second_smallest_pos = slot_pos(res_r[SW-1 -: SW]);
  assign out_largest_val         = slot_val(res_r[4*SW-1 -: SW], VAL_MIN);
  assign out_second_largest_val  = slot_val(res_r[3*SW-1 -: SW], VAL_MIN);
  assign out_smallest_val        = slot_val(res_r[2*SW-1 -: SW], VAL_MAX);
  assign out_second_smallest_val = slot_val(res_r[SW-1 -: SW], VAL_MAX);

endmodule

[verif/range_top_two_extremes_tree_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_top_two_extremes_tree_tb
// drives writes and range queries into the top-two extremes tree, predicts
// each query answer from a shadow array and checks every result transfer
// ----------------------------------------------------------------------------
module range_top_two_extremes_tree_tb;
  import rtt_pkg::*;

  localparam int DEPTH = 1024;
  localparam int PW = $clog2(DEPTH);
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic signed [PW:0]    pos [4];
    logic signed [VAL_W-1:0] val [4];
  } answer_t;

  class answer_board;
    logic signed [VAL_W-1:0] shadow [DEPTH];
    bit written [DEPTH];
    answer_t pending [$];
    int errors;
    int checked;

    function new();
      errors = 0;
      checked = 0;
      foreach (written[i]) written[i] = 0;
    endfunction

    function bit above(int x, int y, bit want_max);
      if (x < 0) return 0;
      if (y < 0) return 1;
      if (shadow[x] != shadow[y]) return want_max ? shadow[x] > shadow[y] : shadow[x] < shadow[y];
      return x < y;
    endfunction

    function void note_item(logic act, int pos, int rend, logic signed [VAL_W-1:0] v);
      answer_t a;
      int b1, b2, s1, s2, hi;
      if (act == ACT_WRITE) begin
        shadow[pos] = v;
        written[pos] = 1;
        return;
      end
      hi = rend > DEPTH ? DEPTH : rend;
      b1 = -1; b2 = -1; s1 = -1; s2 = -1;
      for (int i = pos; i < hi; i++) begin
        if (!written[i]) continue;
        if (above(i, b1, 1)) begin b2 = b1; b1 = i; end
        else if (above(i, b2, 1)) b2 = i;
        if (above(i, s1, 0)) begin s2 = s1; s1 = i; end
        else if (above(i, s2, 0)) s2 = i;
      end
      a.pos[0] = (PW+1)'(b1); a.pos[1] = (PW+1)'(b2);
      a.pos[2] = (PW+1)'(s1); a.pos[3] = (PW+1)'(s2);
      for (int j = 0; j < 4; j++)
        a.val[j] = a.pos[j] >= 0 ? shadow[a.pos[j]] : (j < 2 ? VAL_MIN : VAL_MAX);
      pending.push_back(a);
    endfunction

    function void check_result(answer_t got);
      answer_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pos %0d", $time, got.pos[0]);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      for (int j = 0; j < 4; j++) begin
        if (got.pos[j] !== e.pos[j]) begin
          $display("%0t: pos[%0d] expected %0d actual %0d", $time, j, e.pos[j], got.pos[j]);
          errors++;
        end
        if (got.val[j] !== e.val[j]) begin
          $display("%0t: val[%0d] expected %0d actual %0d", $time, j, e.val[j], got.val[j]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_action;
  logic [PW-1:0] in_position;
  logic [PW:0] in_range_end;
  logic signed [VAL_W-1:0] in_value;
  logic out_valid;
  logic out_stall;
  logic signed [PW:0] o_lp, o_slp, o_sp, o_ssp;
  logic signed [VAL_W-1:0] o_lv, o_slv, o_sv, o_ssv;

  answer_board board;
  bit calm;
  bit hold_off;
  int idle_cycles;
  int queries;
  int writes;

  range_top_two_extremes_tree #(.DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_position(in_position), .in_range_end(in_range_end), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_largest_pos(o_lp), .out_second_largest_pos(o_slp),
    .out_smallest_pos(o_sp), .out_second_smallest_pos(o_ssp),
    .out_largest_val(o_lv), .out_second_largest_val(o_slv),
    .out_smallest_val(o_sv), .out_second_smallest_val(o_ssv)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(logic act, int pos, int rend, logic signed [VAL_W-1:0] v);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_position <= PW'(pos);
    in_range_end <= (PW+1)'(rend);
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(act, pos, rend, v);
    if (act == ACT_QUERY) queries++; else writes++;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(5))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return $urandom_range(3);
      3: return $signed($urandom_range(7)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // small sizes keep positions clustered so duplicates and ties happen often
  task automatic random_item();
    int p, e;
    p = $urandom_range(3) == 0 ? $urandom_range(DEPTH - 1) : $urandom_range(40);
    if ($urandom_range(2) == 0) send_item(ACT_WRITE, p, $urandom_range(2047), pick_value());
    else begin
      case ($urandom_range(7))
        0: e = $urandom_range(2047);
        1: e = p;
        2: e = DEPTH;
        default: e = p + $urandom_range(48);
      endcase
      send_item(ACT_QUERY, p, e, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 0;
    else out_stall <= hold_off || (!calm && $urandom_range(99) < 7);
  end

  always @(posedge clk) begin
    answer_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.pos[0] = o_lp; got.pos[1] = o_slp; got.pos[2] = o_sp; got.pos[3] = o_ssp;
      got.val[0] = o_lv; got.val[1] = o_slv; got.val[2] = o_sv; got.val[3] = o_ssv;
      board.check_result(got);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("range_top_two_extremes_tree_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int waited;
    board = new();
    rst_n = 0;
    in_valid = 0;
    in_action = ACT_WRITE;
    in_position = '0;
    in_range_end = '0;
    in_value = '0;
    calm = 0;
    hold_off = 0;
    queries = 0;
    writes = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_item(ACT_QUERY, 0, DEPTH, 0);
    send_item(ACT_WRITE, 5, 0, 7);
    send_item(ACT_QUERY, 0, 2047, 0);
    send_item(ACT_WRITE, 0, 0, VAL_MIN);
    send_item(ACT_WRITE, DEPTH - 1, 0, VAL_MAX);
    send_item(ACT_WRITE, 6, 0, 7);
    send_item(ACT_WRITE, 7, 0, VAL_MIN);
    send_item(ACT_QUERY, 0, DEPTH, 0);
    send_item(ACT_QUERY, 5, 7, 0);
    send_item(ACT_QUERY, 7, 5, 0);
    send_item(ACT_QUERY, 6, 6, 0);
    send_item(ACT_QUERY, DEPTH - 1, 2047, 0);
    send_item(ACT_QUERY, DEPTH - 1, DEPTH - 1, 0);
    send_item(ACT_WRITE, 8, 0, VAL_MAX);
    send_item(ACT_QUERY, 0, 10, 0);
    send_item(ACT_WRITE, 5, 0, -1);
    send_item(ACT_QUERY, 1, 9, -1);
    send_item(ACT_QUERY, 0, 1, 0);

    for (int i = 0; i < 1930; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1200) begin
        fork
          begin
            hold_off = 1;
            repeat (400) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      random_item();
    end
    calm = 0;
    in_valid <= 0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d writes and %0d queries, %0d results checked",
             writes, queries, board.checked);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("range_top_two_extremes_tree_tb: PASS");
    else
      $display("range_top_two_extremes_tree_tb: FAIL");
    $finish;
  end
endmodule
